FILE: sv/csvtok_pkg.sv
// ----------------------------------------------------------------------------
// csvtok_pkg
// Shared types, codes and the per-character step function of the tokenizer.
// ----------------------------------------------------------------------------
package csvtok_pkg;

    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QAW      = $clog2(QDEPTH);
    localparam int unsigned MAX_EV   = 4;

    localparam logic [7:0] SEP_RESET   = 8'd44;
    localparam logic [7:0] QUOTE_RESET = 8'd34;
    localparam logic [7:0] CH_EOF      = 8'd26;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_DEL      = 8'd127;

    localparam logic CFG_SEP   = 1'b0;
    localparam logic CFG_QUOTE = 1'b1;

    typedef enum logic [2:0] {
        MODE_SKIP   = 3'd0,
        MODE_VALUE  = 3'd1,
        MODE_PLAIN  = 3'd2,
        MODE_QUOTED = 3'd3,
        MODE_QSEEN  = 3'd4,
        MODE_CLOSED = 3'd5,
        MODE_IDLE   = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2,
        KIND_LINE = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0]   chr;
        logic [2:0]   count;
        t_kind [3:0]  kinds;
    } t_bundle;

    typedef struct packed {
        t_mode   mode;
        logic    nonempty;
        t_bundle ev;
    } t_step;

    function automatic t_step csvtok_step(
        input t_mode      mode_in,
        input logic       ne_in,
        input logic [7:0] c,
        input logic       last,
        input logic [7:0] sep,
        input logic [7:0] quo
    );
        t_step      s;
        t_mode      m;
        logic       ne;
        logic       again;
        logic       blank;
        logic       ctrl;
        logic [2:0] n;
        m     = mode_in;
        ne    = ne_in;
        again = 1'b1;
        n     = 3'd0;
        blank = (c == CH_SPACE) || (c == CH_TAB);
        ctrl  = (c < CH_SPACE) || (c == CH_DEL);
        s.ev.chr   = c;
        s.ev.kinds = {MAX_EV{KIND_LINE}};
        for (int i = 0; i < MAX_EV; i++) begin
            if (again) begin
                again = 1'b0;
                case (m)
                    MODE_SKIP: begin
                        if (!blank) begin
                            m     = MODE_VALUE;
                            again = 1'b1;
                        end
                    end
                    MODE_CLOSED: begin
                        if (!blank) begin
                            m     = MODE_VALUE;
                            again = (c != sep);
                        end
                    end
                    MODE_QSEEN: begin
                        if (c == quo) begin
                            s.ev.kinds[n[1:0]] = KIND_BYTE;
                            n  = n + 3'd1;
                            ne = 1'b1;
                            m  = MODE_QUOTED;
                        end else begin
                            s.ev.kinds[n[1:0]] = KIND_END;
                            n     = n + 3'd1;
                            ne    = 1'b0;
                            m     = MODE_CLOSED;
                            again = 1'b1;
                        end
                    end
                    MODE_VALUE, MODE_PLAIN, MODE_QUOTED: begin
                        if (ctrl) begin
                            if (c == CH_EOF) begin
                                if (ne) begin
                                    s.ev.kinds[n[1:0]] = KIND_END;
                                    n = n + 3'd1;
                                end
                                ne = 1'b0;
                            end else begin
                                s.ev.kinds[n[1:0]] = KIND_ERR;
                                n = n + 3'd1;
                            end
                            m = MODE_IDLE;
                        end else if (m == MODE_VALUE) begin
                            if (c == quo) begin
                                m = MODE_QUOTED;
                            end else if (c == sep) begin
                                s.ev.kinds[n[1:0]] = KIND_END;
                                n  = n + 3'd1;
                                ne = 1'b0;
                            end else begin
                                m     = MODE_PLAIN;
                                again = 1'b1;
                            end
                        end else if (m == MODE_PLAIN) begin
                            if (c == sep) begin
                                s.ev.kinds[n[1:0]] = KIND_END;
                                n  = n + 3'd1;
                                ne = 1'b0;
                                m  = MODE_SKIP;
                            end else begin
                                s.ev.kinds[n[1:0]] = KIND_BYTE;
                                n  = n + 3'd1;
                                ne = 1'b1;
                            end
                        end else begin
                            if (c == quo) begin
                                m = MODE_QSEEN;
                            end else begin
                                s.ev.kinds[n[1:0]] = KIND_BYTE;
                                n  = n + 3'd1;
                                ne = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (last) begin
            if (m == MODE_QSEEN) begin
                s.ev.kinds[n[1:0]] = KIND_END;
                n = n + 3'd1;
            end else if ((m < MODE_IDLE) && ne) begin
                s.ev.kinds[n[1:0]] = KIND_END;
                n = n + 3'd1;
            end
            s.ev.kinds[n[1:0]] = KIND_LINE;
            n  = n + 3'd1;
            m  = MODE_SKIP;
            ne = 1'b0;
        end
        s.mode     = m;
        s.nonempty = ne;
        s.ev.count = n;
        return s;
    endfunction

endpackage

FILE: sv/csv_field_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit
// Splits a text line, one character a beat, into field bytes, field ends, line ends and errors.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_char_in, i_line_last
//  output    out        o_valid / i_ready    o_event_kind, o_field_byte, o_run_last
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
//  a character is taken every cycle while the 4-entry bundle queue has room
//  each character yields 0 to 4 output beats, one per cycle from the back end while i_ready is high
//  sustained rate is one character a cycle when it averages one beat or less and i_ready stays high
//  reset is synchronous, active low, and restores comma and double quote
//  a stalled output fills the queue, then o_ready drops
// ----------------------------------------------------------------------------
module csv_field_tokenizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_line_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_event_kind,
    output logic [7:0] o_field_byte,
    output logic       o_run_last,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import csvtok_pkg::*;

    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_valid;
    t_bundle push_bundle;
    t_bundle head_bundle;

    csvtok_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_in   (i_char_in),
        .i_line_last (i_line_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_bundle    (push_bundle)
    );

    csvtok_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .o_full   (q_full),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_bundle (head_bundle)
    );

    csvtok_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_bundle     (head_bundle),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_event_kind (o_event_kind),
        .o_field_byte (o_field_byte),
        .o_run_last   (o_run_last)
    );

endmodule

FILE: sv/csvtok_front.sv
// ----------------------------------------------------------------------------
// csvtok_front
// Accepts characters, holds the parse state and config, emits event bundles.
// ----------------------------------------------------------------------------
module csvtok_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_char_in,
    input  logic                  i_line_last,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [7:0]            i_cfg_data,
    input  logic                  i_q_full,
    output logic                  o_push,
    output csvtok_pkg::t_bundle   o_bundle
);
    import csvtok_pkg::*;

    t_mode      r_mode;
    logic       r_nonempty;
    logic [7:0] r_sep;
    logic [7:0] r_quote;
    t_step      step;
    logic       accept;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && !i_q_full;
    assign step     = csvtok_step(r_mode, r_nonempty, i_char_in, i_line_last, r_sep, r_quote);
    assign o_push   = accept && (step.ev.count != 3'd0);
    assign o_bundle = step.ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_SKIP;
            r_nonempty <= 1'b0;
            r_sep      <= SEP_RESET;
            r_quote    <= QUOTE_RESET;
        end else begin
            if (accept) begin
                r_mode     <= step.mode;
                r_nonempty <= step.nonempty;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SEP:   r_sep   <= i_cfg_data;
                    CFG_QUOTE: r_quote <= i_cfg_data;
                endcase
            end
        end
    end

endmodule

FILE: sv/csvtok_queue.sv
// ----------------------------------------------------------------------------
// csvtok_queue
// Small bundle queue between front and back.
// ----------------------------------------------------------------------------
module csvtok_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  csvtok_pkg::t_bundle   i_bundle,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output csvtok_pkg::t_bundle   o_bundle
);
    import csvtok_pkg::*;

    t_bundle        r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;

    assign o_full   = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_bundle = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

endmodule

FILE: sv/csvtok_back.sv
// ----------------------------------------------------------------------------
// csvtok_back
// Walks each bundle one event a beat into the output register.
// ----------------------------------------------------------------------------
module csvtok_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  csvtok_pkg::t_bundle   i_bundle,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_event_kind,
    output logic [7:0]            o_field_byte,
    output logic                  o_run_last
);
    import csvtok_pkg::*;

    logic [1:0] r_sub;
    logic       r_valid;
    t_kind      r_kind;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;
    logic       at_end;
    t_kind      cur_kind;

    assign load     = (!r_valid || i_ready) && i_q_valid;
    assign at_end   = ({1'b0, r_sub} + 3'd1) == i_bundle.count;
    assign cur_kind = i_bundle.kinds[r_sub];
    assign o_pop    = load && at_end;

    assign o_valid      = r_valid;
    assign o_event_kind = r_kind;
    assign o_field_byte = r_byte;
    assign o_run_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= at_end ? 2'd0 : r_sub + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= cur_kind;
            r_byte <= (cur_kind == KIND_BYTE) ? i_bundle.chr : 8'd0;
            r_last <= at_end;
        end
    end

    a_sub_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> ({1'b0, r_sub} < i_bundle.count))
        else $error("event index past bundle count");

    a_line_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_kind == KIND_LINE)) |-> r_last)
        else $error("line end not last beat of its character");

    a_sub_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_sub == 2'd0))
        else $error("event index not rewound after bundle done");

endmodule

FILE: tb/csv_field_tokenizer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit_test
// Drives text lines into the tokenizer one character a beat and checks every
// output beat against a local tokenizer, or typed beats on some rows of the
// short hand-picked table that comes first, then random lines under several
// separator and quote settings, most with gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_unit_test;
    import csvtok_pkg::*;

    localparam int PREDICT     = -1;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASES      = 6;
    localparam int PHASE_CHARS = 52;
    localparam int SETTLE      = 10;

    typedef struct {
        t_kind      kind;
        logic [7:0] fbyte;
        logic       last;
    } token_beat_t;

    typedef struct {
        logic [7:0] c;
        logic       last;
        int         typed_n;
        t_kind      k0;
        logic [7:0] b0;
        t_kind      k1;
    } stim_row_t;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_ready;
    logic [7:0] i_char_in   = 8'd0;
    logic       i_line_last = 1'b0;
    logic       o_valid;
    logic       i_ready     = 1'b0;
    logic [1:0] o_event_kind;
    logic [7:0] o_field_byte;
    logic       o_run_last;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_index = CFG_SEP;
    logic [7:0] i_cfg_data  = 8'd0;

    // hand-typed expectation that travels with the beat
    int         row_typed_n = PREDICT;
    t_kind      row_kind0   = KIND_BYTE;
    logic [7:0] row_byte0   = 8'd0;
    t_kind      row_kind1   = KIND_BYTE;

    t_mode       tok_mode;
    logic        tok_nonempty;
    logic [7:0]  tok_sep;
    logic [7:0]  tok_quote;
    token_beat_t step_beats[$];
    token_beat_t expected_beats[$];

    logic [7:0] cur_sep        = SEP_RESET;
    logic [7:0] cur_quote      = QUOTE_RESET;
    int         send_gap_pct   = 0;
    int         recv_stall_pct = 0;
    int         chars_sent     = 0;
    int         mismatch_count = 0;
    int         stall_cycles   = 0;

    logic [7:0] phase_sep   [PHASES] = '{8'd44, 8'd0, 8'd255, 8'd59, 8'd9, 8'd44};
    logic [7:0] phase_quote [PHASES] = '{8'd34, 8'd255, 8'd0, 8'd59, 8'd39, 8'd34};

    stim_row_t directed_rows [25] = '{
        '{8'd255, 1'b0, 1,       KIND_BYTE, 8'd255, KIND_BYTE},
        '{",",    1'b0, 1,       KIND_END,  8'd0,   KIND_BYTE},
        '{"\"",   1'b0, 0,       KIND_BYTE, 8'd0,   KIND_BYTE},
        '{"x",    1'b0, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{"\"",   1'b0, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{"\"",   1'b0, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{"\"",   1'b0, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{CH_TAB, 1'b0, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{",",    1'b0, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{",",    1'b0, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{8'd0,   1'b0, 1,       KIND_ERR,  8'd0,   KIND_BYTE},
        '{"z",    1'b1, 1,       KIND_LINE, 8'd0,   KIND_BYTE},
        '{"a",    1'b0, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{CH_EOF, 1'b0, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{"q",    1'b1, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{"\"",   1'b0, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{"\"",   1'b1, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{CH_DEL, 1'b1, 2,       KIND_ERR,  8'd0,   KIND_LINE},
        '{"b",    1'b1, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{"c",    1'b0, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{",",    1'b1, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{"\"",   1'b0, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{"k",    1'b0, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{"\"",   1'b0, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE},
        '{"m",    1'b1, PREDICT, KIND_BYTE, 8'd0,   KIND_BYTE}
    };

    csv_field_tokenizer_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_char_in    (i_char_in),
        .i_line_last  (i_line_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_event_kind (o_event_kind),
        .o_field_byte (o_field_byte),
        .o_run_last   (o_run_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void add_beat(input t_kind kind, input logic [7:0] fbyte);
        token_beat_t b;
        if (step_beats.size() < MAX_EV) begin
            b.kind  = kind;
            b.fbyte = (kind == KIND_BYTE) ? fbyte : 8'd0;
            b.last  = 1'b0;
            step_beats.push_back(b);
        end
    endfunction

    function automatic void tokenize_char(input logic [7:0] c, input logic last);
        logic blank;
        logic ctrl;
        logic again;
        blank = (c == CH_SPACE) || (c == CH_TAB);
        ctrl  = (c < CH_SPACE) || (c == CH_DEL);
        again = 1'b1;
        step_beats.delete();
        while (again) begin
            again = 1'b0;
            case (tok_mode)
                MODE_SKIP: begin
                    if (!blank) begin
                        tok_mode = MODE_VALUE;
                        again    = 1'b1;
                    end
                end
                MODE_CLOSED: begin
                    // a non-blank separator after a closing quote is taken without the control check
                    if (!blank) begin
                        tok_mode = MODE_VALUE;
                        again    = (c != tok_sep);
                    end
                end
                MODE_QSEEN: begin
                    if (c == tok_quote) begin
                        add_beat(KIND_BYTE, c);
                        tok_nonempty = 1'b1;
                        tok_mode     = MODE_QUOTED;
                    end else begin
                        add_beat(KIND_END, 8'd0);
                        tok_nonempty = 1'b0;
                        tok_mode     = MODE_CLOSED;
                        again        = 1'b1;
                    end
                end
                MODE_VALUE, MODE_PLAIN, MODE_QUOTED: begin
                    if (ctrl) begin
                        if (c == CH_EOF) begin
                            if (tok_nonempty) begin
                                add_beat(KIND_END, 8'd0);
                            end
                            tok_nonempty = 1'b0;
                        end else begin
                            add_beat(KIND_ERR, 8'd0);
                        end
                        tok_mode = MODE_IDLE;
                    end else if (tok_mode == MODE_VALUE) begin
                        // quote wins over an equal separator at a value start
                        if (c == tok_quote) begin
                            tok_mode = MODE_QUOTED;
                        end else if (c == tok_sep) begin
                            add_beat(KIND_END, 8'd0);
                            tok_nonempty = 1'b0;
                        end else begin
                            tok_mode = MODE_PLAIN;
                            again    = 1'b1;
                        end
                    end else if (tok_mode == MODE_PLAIN) begin
                        if (c == tok_sep) begin
                            add_beat(KIND_END, 8'd0);
                            tok_nonempty = 1'b0;
                            tok_mode     = MODE_SKIP;
                        end else begin
                            add_beat(KIND_BYTE, c);
                            tok_nonempty = 1'b1;
                        end
                    end else if (c == tok_quote) begin
                        tok_mode = MODE_QSEEN;
                    end else begin
                        add_beat(KIND_BYTE, c);
                        tok_nonempty = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (last) begin
            if (tok_mode == MODE_QSEEN) begin
                add_beat(KIND_END, 8'd0);
            end else if (tok_mode != MODE_IDLE && tok_nonempty) begin
                add_beat(KIND_END, 8'd0);
            end
            add_beat(KIND_LINE, 8'd0);
            tok_mode     = MODE_SKIP;
            tok_nonempty = 1'b0;
        end
    endfunction

    always @(posedge i_clk) begin
        token_beat_t b;
        token_beat_t want;
        if (!i_rst_n) begin
            tok_mode     = MODE_SKIP;
            tok_nonempty = 1'b0;
            tok_sep      = SEP_RESET;
            tok_quote    = QUOTE_RESET;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SEP) begin
                    tok_sep = i_cfg_data;
                end else begin
                    tok_quote = i_cfg_data;
                end
            end
            if (i_valid && o_ready) begin
                tokenize_char(i_char_in, i_line_last);
                if (row_typed_n != PREDICT) begin
                    step_beats.delete();
                    if (row_typed_n > 0) begin
                        add_beat(row_kind0, row_byte0);
                    end
                    if (row_typed_n > 1) begin
                        add_beat(row_kind1, 8'd0);
                    end
                end
                if (step_beats.size() > 0) begin
                    b      = step_beats.pop_back();
                    b.last = 1'b1;
                    step_beats.push_back(b);
                end
                foreach (step_beats[k]) begin
                    expected_beats.push_back(step_beats[k]);
                end
            end
            if (o_valid && i_ready) begin
                if (expected_beats.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("unexpected beat: kind %0d byte %02h last %0b",
                                 o_event_kind, o_field_byte, o_run_last);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_beats.pop_front();
                    if (o_event_kind !== want.kind || o_field_byte !== want.fbyte ||
                        o_run_last !== want.last) begin
                        if (mismatch_count < 10) begin
                            $display("beat mismatch: exp kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
                                     want.kind, want.fbyte, want.last,
                                     o_event_kind, o_field_byte, o_run_last);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic push_char(input logic [7:0] c, input logic last, input int typed_n,
                             input t_kind k0, input logic [7:0] b0, input t_kind k1);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_in   <= c;
        i_line_last <= last;
        row_typed_n <= typed_n;
        row_kind0   <= k0;
        row_byte0   <= b0;
        row_kind1   <= k1;
        do @(posedge i_clk); while (!o_ready);
        chars_sent++;
    endtask

    task automatic send_byte(input logic [7:0] c, input logic last);
        push_char(c, last, PREDICT, KIND_BYTE, 8'd0, KIND_BYTE);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_beats.size() != 0) begin
            @(posedge i_clk);
        end
        // a character with no beats may still be in flight
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_chars(input logic [7:0] sep, input logic [7:0] quo);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SEP;
        i_cfg_data  <= sep;
        @(posedge i_clk);
        i_cfg_index <= CFG_QUOTE;
        i_cfg_data  <= quo;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_sep   = sep;
        cur_quote = quo;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] v;
        do v = 8'($urandom_range(255, 32));
        while (v == CH_DEL || v == cur_sep || v == cur_quote);
        return v;
    endfunction

    task automatic send_line(input logic broken);
        logic [7:0] text[$];
        logic [7:0] bad;
        int         nfields;
        int         len;
        int         pick;
        nfields = $urandom_range(4, 1);
        for (int f = 0; f < nfields; f++) begin
            if ($urandom_range(3) == 0) begin
                text.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
            end
            len = $urandom_range(4);
            if ($urandom_range(1)) begin
                text.push_back(cur_quote);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(5);
                    if (pick == 0) begin
                        text.push_back(cur_quote);
                        text.push_back(cur_quote);
                    end else if (pick == 1) begin
                        text.push_back(cur_sep);
                    end else if (pick == 2) begin
                        text.push_back(CH_SPACE);
                    end else begin
                        text.push_back(text_byte());
                    end
                end
                text.push_back(cur_quote);
                if ($urandom_range(2) == 0) begin
                    text.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
                end
            end else begin
                for (int i = 0; i < len; i++) begin
                    text.push_back(text_byte());
                end
            end
            if (f < nfields - 1) begin
                text.push_back(cur_sep);
            end
        end
        if (broken) begin
            pick = $urandom_range(3);
            if (pick == 0) begin
                bad = CH_EOF;
            end else if (pick == 1) begin
                bad = CH_DEL;
            end else begin
                bad = 8'($urandom_range(31));
            end
            text.insert($urandom_range(text.size()), bad);
        end
        if (text.size() == 0) begin
            text.push_back(text_byte());
        end
        foreach (text[i]) begin
            send_byte(text[i], i == text.size() - 1);
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom_range(255)), $urandom_range(4) == 0);
        end
    endtask

    task automatic run_random_phase(input int budget);
        int   first;
        int   pick;
        logic paused;
        first  = chars_sent;
        paused = 1'b0;
        while (chars_sent - first < budget) begin
            if (!paused && chars_sent - first >= budget / 2) begin
                drain_results();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_line(1'b0);
            end else if (pick < 88) begin
                send_line(1'b1);
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_gap_pct   = 14;
        recv_stall_pct = 53;
        foreach (directed_rows[r]) begin
            push_char(directed_rows[r].c, directed_rows[r].last, directed_rows[r].typed_n,
                      directed_rows[r].k0, directed_rows[r].b0, directed_rows[r].k1);
        end
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            if (p > 0) begin
                load_chars(phase_sep[p], phase_quote[p]);
            end
            send_gap_pct   = (p < 2) ? 14 : (p < 4) ? 53 : 0;
            recv_stall_pct = (p < 2) ? 53 : (p < 4) ? 14 : 0;
            run_random_phase(PHASE_CHARS);
        end
        drain_results();
        if (mismatch_count == 0 && expected_beats.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
